// File: rtl/afc_pkg.sv
`default_nettype none

package afc_pkg;

  // Fixed field widths of the ports
  localparam int WORD_W   = 32;
  localparam int REG_W    = 64;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 3;

  // Arithmetic format of coordinates and matrix entries
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int TERM_W = (PROD_W > COORD_WIDTH + FRAC_BITS) ? PROD_W
                                                             : COORD_WIDTH + FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam int CMP_W  = SUM_W + 1;

  // w > 0.001 in the product format: floor(2^(2*FRAC_BITS) / 1000)
  localparam longint unsigned W_THRESH = (64'd1 << (2 * FRAC_BITS)) / 64'd1000;

  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [CMP_W-1:0]       cmp_t;
  typedef logic        [REG_W-1:0]       reg_word_t;

  // Identity matrix after reset
  localparam reg_word_t REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

endpackage

`default_nettype wire

// File: rtl/aabb_frustum_cull_unit.sv
// Pipeline: a request accepted on in_* passes through the input, product, clip-sum
//   and result registers before its result shows on out_*.
// Throughput: one box per cycle unless stalled; stalls hold only stages with a request.
// Reset (synchronous, rst_n low): all stage valids clear and the matrix returns
//   to the identity.
`default_nettype none

module aabb_frustum_cull_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // box channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_min_x,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_min_y,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_min_z,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_max_x,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_max_y,
  input  wire logic signed [afc_pkg::WORD_W-1:0] in_box_max_z,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_visible,
  // matrix registers
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [afc_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [afc_pkg::REG_W-1:0]         pwdata,
  output logic      [afc_pkg::REG_W-1:0]         prdata,
  output logic                                   pready
);

  // ---------------------------------------------------------------- config
  afc_pkg::reg_word_t cfg_regs_r [afc_pkg::NUM_REGS];
  logic [afc_pkg::IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[afc_pkg::ADDR_W-1:3];
  assign prdata  = cfg_regs_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::NUM_REGS; i++) begin
        cfg_regs_r[i] <= afc_pkg::REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_regs_r[cfg_idx] <= pwdata;
    end
  end

  // Matrix entries: low COORD_WIDTH bits of each 32-bit half
  afc_pkg::coord_t mat [afc_pkg::NUM_ROWS][afc_pkg::NUM_COLS];

  always_comb begin
    for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < afc_pkg::NUM_COLS; c++) begin
        if (c % 2 == 1) begin
          mat[r][c] = afc_pkg::coord_t'(cfg_regs_r[r*2 + c/2][32 +: afc_pkg::COORD_WIDTH]);
        end else begin
          mat[r][c] = afc_pkg::coord_t'(cfg_regs_r[r*2 + c/2][0 +: afc_pkg::COORD_WIDTH]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- flow control
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_ld, s2_ld, s3_ld, out_ld;

  assign out_ld   = !out_valid_r || !out_stall;
  assign s3_ld    = !s3_valid_r  || out_ld;
  assign s2_ld    = !s2_valid_r  || s3_ld;
  assign s1_ld    = !s1_valid_r  || s2_ld;
  assign in_stall = !s1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ld) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ld) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_ld) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: box
  afc_pkg::coord_t s1_lo_r [afc_pkg::NUM_AXES];
  afc_pkg::coord_t s1_hi_r [afc_pkg::NUM_AXES];

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_lo_r[0] <= afc_pkg::coord_t'(in_box_min_x[afc_pkg::COORD_WIDTH-1:0]);
      s1_lo_r[1] <= afc_pkg::coord_t'(in_box_min_y[afc_pkg::COORD_WIDTH-1:0]);
      s1_lo_r[2] <= afc_pkg::coord_t'(in_box_min_z[afc_pkg::COORD_WIDTH-1:0]);
      s1_hi_r[0] <= afc_pkg::coord_t'(in_box_max_x[afc_pkg::COORD_WIDTH-1:0]);
      s1_hi_r[1] <= afc_pkg::coord_t'(in_box_max_y[afc_pkg::COORD_WIDTH-1:0]);
      s1_hi_r[2] <= afc_pkg::coord_t'(in_box_max_z[afc_pkg::COORD_WIDTH-1:0]);
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  // Corners share terms: each row needs only entry * min and entry * max per axis.
  afc_pkg::prod_t prod_lo_r [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];
  afc_pkg::prod_t prod_hi_r [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES];

  always_ff @(posedge clk) begin
    if (s2_ld && s1_valid_r) begin
      for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
        for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
          prod_lo_r[r][k] <= afc_pkg::prod_t'(mat[r][k]) * afc_pkg::prod_t'(s1_lo_r[k]);
          prod_hi_r[r][k] <= afc_pkg::prod_t'(mat[r][k]) * afc_pkg::prod_t'(s1_hi_r[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: clip sums
  afc_pkg::sum_t clip_r   [afc_pkg::NUM_CORNERS][afc_pkg::NUM_ROWS];
  afc_pkg::sum_t clip_nxt [afc_pkg::NUM_CORNERS][afc_pkg::NUM_ROWS];
  afc_pkg::sum_t offs     [afc_pkg::NUM_ROWS];

  always_comb begin
    for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
      // column 3 times 1.0
      offs[r] = afc_pkg::sum_t'(mat[r][3]) <<< afc_pkg::FRAC_BITS;
    end
    for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
      for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
        clip_nxt[c][r] = offs[r]
          + afc_pkg::sum_t'((c % 2 == 1)       ? prod_hi_r[r][0] : prod_lo_r[r][0])
          + afc_pkg::sum_t'(((c / 2) % 2 == 1) ? prod_hi_r[r][1] : prod_lo_r[r][1])
          + afc_pkg::sum_t'(((c / 4) % 2 == 1) ? prod_hi_r[r][2] : prod_lo_r[r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ld && s2_valid_r) begin
      clip_r <= clip_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4: plane tests
  logic [afc_pkg::NUM_CORNERS-1:0] in_left, in_right, in_bottom, in_top, in_near, in_far;
  logic visible_nxt;
  logic out_visible_r;

  always_comb begin
    afc_pkg::cmp_t cx, cy, cz, cw;
    logic          w_ok;
    for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
      cx   = afc_pkg::cmp_t'(clip_r[c][afc_pkg::ROW_X]);
      cy   = afc_pkg::cmp_t'(clip_r[c][afc_pkg::ROW_Y]);
      cz   = afc_pkg::cmp_t'(clip_r[c][afc_pkg::ROW_Z]);
      cw   = afc_pkg::cmp_t'(clip_r[c][afc_pkg::ROW_W]);
      // skip corners at or behind the w threshold
      w_ok = cw > afc_pkg::cmp_t'(afc_pkg::W_THRESH);
      in_left[c]   = w_ok && (cx + cw > 0);
      in_right[c]  = w_ok && (cw - cx > 0);
      in_bottom[c] = w_ok && (cy + cw > 0);
      in_top[c]    = w_ok && (cw - cy > 0);
      in_near[c]   = w_ok && (cz > 0);
      in_far[c]    = w_ok && (cw - cz > 0);
    end
    // culled when some plane has no corner inside it
    visible_nxt = (|in_left) && (|in_right) && (|in_bottom) &&
                  (|in_top) && (|in_near) && (|in_far);
  end

  always_ff @(posedge clk) begin
    if (out_ld && s3_valid_r) begin
      out_visible_r <= visible_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

`default_nettype wire

// File: rtl/afc_checker.sv
`default_nettype none

module afc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_visible,
  input wire logic pready
);

  // A held result keeps its request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_visible))
    else $error("result changed while stalled");

  // With an empty output register nothing upstream can be held back
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // Stall the input only behind a held result
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("register port not ready");

endmodule

bind aabb_frustum_cull_unit afc_checker u_afc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_visible (out_visible),
  .pready      (pready)
);

`default_nettype wire

// File: bench/tb_aabb_frustum_cull_unit.sv
`timescale 1ns / 1ps

module tb_aabb_frustum_cull_unit;

  typedef afc_pkg::coord_t    coord_t;
  typedef afc_pkg::reg_word_t reg_word_t;

  localparam int FRAC        = afc_pkg::FRAC_BITS;
  localparam int NUM_REGS    = afc_pkg::NUM_REGS;
  localparam int NUM_CORNERS = afc_pkg::NUM_CORNERS;
  localparam int ADDR_W      = afc_pkg::ADDR_W;
  localparam int ROW_X       = afc_pkg::ROW_X;
  localparam int ROW_Y       = afc_pkg::ROW_Y;
  localparam int ROW_Z       = afc_pkg::ROW_Z;
  localparam int ROW_W       = afc_pkg::ROW_W;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 5000;
  localparam int DRAIN_PAD   = 6;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // w must exceed 0.001, i.e. floor(2^(2*FRAC)/1000) in product format
  localparam wide_t W_MIN = wide_t'((64'd1 << (2 * FRAC)) / 64'd1000);

  localparam coord_t FX_ONE  = 32'sh0001_0000;
  localparam coord_t FX_HALF = 32'sh0000_8000;
  localparam coord_t FX_MAXV = 32'sh7FFF_FFFF;
  localparam coord_t FX_MINV = 32'sh8000_0000;

  localparam reg_word_t IDENTITY [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  class cull_scoreboard;
    reg_word_t mat [NUM_REGS];
    bit        visible_q [$];
    int        n_boxes;
    int        n_visible;
    int        n_culled;
    int        n_bad;

    function new();
      mat = IDENTITY;
    endfunction

    function void load_reg(int idx, reg_word_t value);
      mat[idx] = value;
    endfunction

    function int pending();
      return visible_q.size();
    endfunction

    function void flag(string what);
      n_bad++;
      if (n_bad <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function coord_t entry(int row, int col);
      reg_word_t r;
      r = mat[row * 2 + col / 2];
      return coord_t'(col[0] ? r[63:32] : r[31:0]);
    endfunction

    function wide_t clip(int row, coord_t x, coord_t y, coord_t z);
      return wide_t'(entry(row, 0)) * wide_t'(x) + wide_t'(entry(row, 1)) * wide_t'(y)
           + wide_t'(entry(row, 2)) * wide_t'(z) + (wide_t'(entry(row, 3)) <<< FRAC);
    endfunction

    // Exact clip test over all eight corners; a plane culls when no corner clears it
    function bit box_visible(box_t b);
      wide_t  cx, cy, cz, cw;
      coord_t x, y, z;
      bit     out_l, out_r, out_b, out_t, out_n, out_f;
      out_l = 1'b1; out_r = 1'b1; out_b = 1'b1;
      out_t = 1'b1; out_n = 1'b1; out_f = 1'b1;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        x  = c[0] ? b.max_x : b.min_x;
        y  = c[1] ? b.max_y : b.min_y;
        z  = c[2] ? b.max_z : b.min_z;
        cx = clip(ROW_X, x, y, z);
        cy = clip(ROW_Y, x, y, z);
        cz = clip(ROW_Z, x, y, z);
        cw = clip(ROW_W, x, y, z);
        if (cw > W_MIN) begin
          if (cx + cw > 0) out_l = 1'b0;
          if (cw - cx > 0) out_r = 1'b0;
          if (cy + cw > 0) out_b = 1'b0;
          if (cw - cy > 0) out_t = 1'b0;
          if (cz > 0)      out_n = 1'b0;
          if (cw - cz > 0) out_f = 1'b0;
        end
      end
      return !(out_l | out_r | out_b | out_t | out_n | out_f);
    endfunction

    function void note_box(box_t b);
      bit vis;
      vis = box_visible(b);
      visible_q = {visible_q, vis};
      n_boxes++;
      if (vis) n_visible++;
      else n_culled++;
    endfunction

    function void check_visible(bit got);
      bit want;
      if (visible_q.size() == 0) begin
        flag($sformatf("result visible=%0b with no request outstanding", got));
      end else begin
        want = visible_q.pop_front();
        if (got !== want) flag($sformatf("visible expected %0b actual %0b", want, got));
      end
    endfunction

    function void check_reg(int idx, reg_word_t got);
      if (got !== mat[idx])
        flag($sformatf("reg %0d expected %h actual %h", idx, mat[idx], got));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  coord_t                in_box_min_x = '0;
  coord_t                in_box_min_y = '0;
  coord_t                in_box_min_z = '0;
  coord_t                in_box_max_x = '0;
  coord_t                in_box_max_y = '0;
  coord_t                in_box_max_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_visible;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  reg_word_t             pwdata = '0;
  reg_word_t             prdata;
  logic                  pready;

  cull_scoreboard sb = new();

  bit no_gaps     = 1'b0;
  bit hold_armed  = 1'b0;
  bit hold_done   = 1'b0;
  int n_settings  = 0;
  int n_reads     = 0;

  aabb_frustum_cull_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_visible  (out_visible),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Track requests and results on the edge where they are accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_box({in_box_min_x, in_box_min_y, in_box_min_z,
                     in_box_max_x, in_box_max_y, in_box_max_z});
      if (out_valid && !out_stall) sb.check_visible(out_visible);
    end
  end

  // Receiver: random stalls, one long hold to back the pipe up
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) hold_done = 1'b1;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 26);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
          || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STUCK_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
        $display("FAIL aabb_frustum_cull_unit");
        $finish;
      end
    end
  end

  function automatic reg_word_t pair(coord_t c0, coord_t c1);
    return {c1, c0};
  endfunction

  function automatic coord_t near_coord();
    return coord_t'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  function automatic coord_t rand_entry();
    return coord_t'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic box_t make_box(coord_t ax, coord_t ay, coord_t az,
                                    coord_t bx, coord_t by, coord_t bz);
    return {ax, ay, az, bx, by, bz};
  endfunction

  function automatic box_t random_box();
    box_t   b;
    int     pick;
    coord_t t;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      b = {near_coord(), near_coord(), near_coord(),
           near_coord(), near_coord(), near_coord()};
      // keep most boxes well ordered, leave the rest as given
      if (pick >= 30) begin
        if (b.min_x > b.max_x) begin t = b.min_x; b.min_x = b.max_x; b.max_x = t; end
        if (b.min_y > b.max_y) begin t = b.min_y; b.min_y = b.max_y; b.max_y = t; end
        if (b.min_z > b.max_z) begin t = b.min_z; b.min_z = b.max_z; b.max_z = t; end
      end
    end
    return b;
  endfunction

  task automatic cfg_write(int idx, reg_word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.load_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(int idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * 8);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.check_reg(idx, prdata);
    n_reads++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input reg_word_t m [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, m[i]);
    for (int i = 0; i < NUM_REGS; i++) cfg_read_check(i);
    n_settings++;
  endtask

  task automatic load_random(bit full_range);
    reg_word_t m [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++)
      m[i] = full_range ? {$urandom, $urandom} : pair(rand_entry(), rand_entry());
    load_matrix(m);
  endtask

  task automatic send_box(box_t b);
    while (!no_gaps && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_box_min_x <= b.min_x;
    in_box_min_y <= b.min_y;
    in_box_min_z <= b.min_z;
    in_box_max_x <= b.max_x;
    in_box_max_y <= b.max_y;
    in_box_max_z <= b.max_z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_box(random_box());
  endtask

  // Drop valid and wait until every outstanding request has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin
    reg_word_t m [NUM_REGS];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix must read back as identity
    for (int i = 0; i < NUM_REGS; i++) cfg_read_check(i);

    // identity: w is 1 everywhere
    send_box(make_box('0, '0, '0, '0, '0, '0));
    send_box(make_box(-FX_HALF, -FX_HALF, FX_HALF >>> 1, FX_HALF, FX_HALF, 32'sh0000_C000));
    send_box(make_box(-3 * FX_ONE, '0, FX_HALF, -2 * FX_ONE, FX_HALF, FX_HALF));
    send_box(make_box(-10 * FX_ONE, -10 * FX_ONE, -10 * FX_ONE,
                      10 * FX_ONE, 10 * FX_ONE, 10 * FX_ONE));
    send_box(make_box(FX_HALF, FX_HALF, 32'sh0000_C000, -FX_HALF, -FX_HALF, FX_HALF >>> 1));
    send_box(make_box(FX_MINV, FX_MINV, FX_MINV, FX_MINV, FX_MINV, FX_MINV));
    send_box(make_box(FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV));
    send_box(make_box(FX_MINV, FX_MINV, FX_MINV, FX_MAXV, FX_MAXV, FX_MAXV));
    // corners sitting exactly on a plane do not clear it
    send_box(make_box(-FX_ONE, '0, FX_HALF, -FX_ONE, '0, FX_HALF));
    send_box(make_box(FX_ONE, '0, FX_HALF, FX_ONE, '0, FX_HALF));
    send_box(make_box('0, '0, '0, '0, '0, '0));
    send_box(make_box('0, '0, FX_ONE, '0, '0, FX_ONE));
    send_box(make_box(-FX_ONE, -FX_ONE, '0, FX_ONE, FX_ONE, FX_ONE));
    send_random(300);
    drain();

    // w = -z in lsb units, z' a hair above zero: probes the w threshold
    m = IDENTITY;
    m[4] = '0;
    m[5] = pair('0, 32'sd1);
    m[6] = '0;
    m[7] = pair(-32'sd1, '0);
    load_matrix(m);
    send_box(make_box('0, '0, -32'sd4294967, '0, '0, -32'sd4294967));
    send_box(make_box('0, '0, -32'sd4294968, '0, '0, -32'sd4294968));
    send_box(make_box('0, '0, -32'sd4294967, '0, '0, -32'sd4294968));
    send_box(make_box('0, '0, FX_ONE, FX_ONE, FX_ONE, 2 * FX_ONE));
    drain();

    // perspective-like: w = -z, depth slab z in (-2, -1); receiver holds long here
    m = IDENTITY;
    m[5] = pair(-2 * FX_ONE, -2 * FX_ONE);
    m[7] = pair(-FX_ONE, '0);
    load_matrix(m);
    hold_armed = 1'b1;
    send_random(400);
    drain();

    load_random(1'b0);
    no_gaps = 1'b1;
    send_random(150);
    no_gaps = 1'b0;
    send_random(250);
    drain();

    load_random(1'b0);
    send_random(250);
    drain();

    for (int i = 0; i < NUM_REGS; i++) m[i] = {FX_MINV, FX_MINV};
    load_matrix(m);
    send_box(make_box(FX_MINV, FX_MINV, FX_MINV, FX_MINV, FX_MINV, FX_MINV));
    send_box(make_box(FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV, FX_MAXV));
    send_box(make_box(FX_MINV, FX_MINV, FX_MINV, FX_MAXV, FX_MAXV, FX_MAXV));
    send_random(60);
    drain();

    for (int i = 0; i < NUM_REGS; i++) m[i] = {FX_MAXV, FX_MAXV};
    load_matrix(m);
    send_box(make_box(FX_MINV, FX_MINV, FX_MINV, FX_MAXV, FX_MAXV, FX_MAXV));
    send_box(make_box(FX_MAXV, FX_MAXV, FX_MAXV, FX_MINV, FX_MINV, FX_MINV));
    send_random(60);
    drain();

    load_random(1'b1);
    send_random(200);
    drain();

    load_random(1'b1);
    send_random(100);
    drain();

    load_matrix(IDENTITY);
    send_random(200);
    drain();

    $display("covered %0d boxes (%0d visible, %0d culled) under %0d matrices",
             sb.n_boxes, sb.n_visible, sb.n_culled, n_settings);
    $display("%0d register reads checked, %0d mismatches, %0d results outstanding",
             n_reads, sb.n_bad, sb.pending());
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("PASS aabb_frustum_cull_unit");
    end else begin
      $display("FAIL aabb_frustum_cull_unit");
    end
    $finish;
  end

endmodule
